### design/falc_pkg.sv
// falc_pkg: shared types and constants of the fully associative lru cache
// no dependencies; compiled first

package falc_pkg;

  // word address width of the request channel
  localparam int ADDR_W = 12;

  // lru age counters
  localparam int AGE_W = 4;
  localparam logic [AGE_W-1:0] AGE_MAX = 4'd15;
  localparam logic [AGE_W-1:0] AGE_RESET = 4'd8;

  // request type codes
  localparam logic REQ_READ = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  // commands from the controller to the datapath
  typedef struct packed {
    logic clear;     // reset sweep of the backing memory
    logic load;      // capture an accepted request transaction
    logic lookup;    // tag compare, victim choice, age update
    logic fill_rd;   // read one line word from backing memory
    logic finish;    // write-through and result assembly
    logic out_load;  // load the result register
  } falc_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic clear_last;  // last word of the reset sweep
    logic hit;         // tag matched a valid block
    logic fill_last;   // last line word being read
    logic out_free;    // result register can take a new result
  } falc_status_t;

endpackage

### design/falc_if.sv
// falc_req_if, falc_rsp_if: valid/ready channels of the cache
// request carries type, address and write data; response carries hit, data, block

interface falc_req_if #(
  parameter int DATA_WIDTH = 32
);
  logic                         valid;
  logic                         ready;
  logic                         req_type;
  logic [11:0]                  address;
  logic signed [DATA_WIDTH-1:0] write_data;

  modport source (output valid, output req_type, output address, output write_data,
                  input ready);
  modport sink (input valid, input req_type, input address, input write_data,
                output ready);
endinterface

interface falc_rsp_if #(
  parameter int DATA_WIDTH = 32,
  parameter int IDX_W = 3
);
  logic                         valid;
  logic                         ready;
  logic                         hit;
  logic signed [DATA_WIDTH-1:0] read_data;
  logic [IDX_W-1:0]             block_index;

  modport source (output valid, output hit, output read_data, output block_index,
                  input ready);
  modport sink (input valid, input hit, input read_data, input block_index,
                output ready);
endinterface

### design/fully_assoc_lru_cache.sv
// fully_assoc_lru_cache: top level joining the sequencer and the datapath
// depends on falc_pkg, falc_if, falc_ctrl, falc_dp
//
// Fully associative write-through, write-allocate cache with lru replacement.
// req channel: one transaction per access (req_type, address, write_data).
// rsp channel: one transaction per access (hit, read_data, block_index).
// A hit passes from acceptance through the lookup and finish states to the
// result register; the next request is taken in the cycle the result is
// loaded. A miss goes through lookup, a line fill and finish; the single
// backing-memory port reads the line one word a cycle, and the write-through
// uses the same port after the fill.
// After reset a sweep loads every backing-memory word with its own address,
// with req.ready low; valid bits clear and all ages start at 8.
// If the receiver stalls, the result stays in the output register; one more
// request is accepted and worked up to its final step, where it waits.
// Block count, words per block and memory depth are powers of two.

module fully_assoc_lru_cache #(
  parameter int NUM_BLOCKS = 8,
  parameter int WORDS_PER_BLOCK = 4,
  parameter int MEM_WORDS = 4096,
  parameter int DATA_WIDTH = 32
) (
  input logic      clk,
  input logic      rst,
  falc_req_if.sink   req,
  falc_rsp_if.source rsp
);
  import falc_pkg::*;

  localparam int IDX_W = $clog2(NUM_BLOCKS);

  falc_cmd_t    cmd;
  falc_status_t st;

  // sequencer
  falc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .st       (st),
    .cmd      (cmd)
  );

  // datapath
  falc_dp #(
    .NUM_BLOCKS      (NUM_BLOCKS),
    .WORDS_PER_BLOCK (WORDS_PER_BLOCK),
    .MEM_WORDS       (MEM_WORDS),
    .DATA_WIDTH      (DATA_WIDTH),
    .IDX_W           (IDX_W)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .st              (st),
    .in_req_type     (req.req_type),
    .in_address      (req.address),
    .in_write_data   (req.write_data),
    .out_valid       (rsp.valid),
    .out_ready       (rsp.ready),
    .out_hit         (rsp.hit),
    .out_read_data   (rsp.read_data),
    .out_block_index (rsp.block_index)
  );

  // no request is taken during the reset sweep
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    cmd.clear |-> !req.ready)
    else $error("request ready during memory sweep");

  // an accepted request goes to lookup in the next cycle
  a_accept_then_lookup: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> cmd.lookup)
    else $error("accepted request not looked up");

  // a pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!rsp.valid || rsp.ready))
    else $error("result register overwritten");

  // the last line word read leads to the finish step
  a_fill_then_finish: assert property (@(posedge clk) disable iff (rst)
    (cmd.fill_rd && st.fill_last) |=> cmd.finish)
    else $error("line fill did not end in finish");

endmodule

### design/falc_ctrl.sv
// falc_ctrl: sequencer of the cache (reset sweep, lookup, line fill, finish)
// depends on falc_pkg for the command and status structs

module falc_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  falc_pkg::falc_status_t st,
  output falc_pkg::falc_cmd_t    cmd
);
  import falc_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOKUP,
    S_FILL,
    S_FINISH
  } state_t;

  state_t state;
  state_t state_next;

  // command decode and next state
  always_comb begin
    cmd        = '0;
    in_ready   = 1'b0;
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (st.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) state_next = S_LOOKUP;
      end
      S_LOOKUP: begin
        cmd.lookup = 1'b1;
        state_next = st.hit ? S_FINISH : S_FILL;
      end
      S_FILL: begin
        cmd.fill_rd = 1'b1;
        if (st.fill_last) state_next = S_FINISH;
      end
      S_FINISH: begin
        cmd.finish = 1'b1;
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          in_ready     = 1'b1;
          state_next   = in_valid ? S_LOOKUP : S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
    cmd.load = in_ready & in_valid;
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

### design/falc_dp.sv
// falc_dp: cache datapath with tags, ages, line storage, backing memory, result register
// depends on falc_pkg; commanded by falc_ctrl

module falc_dp #(
  parameter int NUM_BLOCKS = 8,
  parameter int WORDS_PER_BLOCK = 4,
  parameter int MEM_WORDS = 4096,
  parameter int DATA_WIDTH = 32,
  parameter int IDX_W = 3
) (
  input  logic                    clk,
  input  logic                    rst,
  input  falc_pkg::falc_cmd_t     cmd,
  output falc_pkg::falc_status_t  st,
  input  logic                    in_req_type,
  input  logic [11:0]             in_address,
  input  logic [DATA_WIDTH-1:0]   in_write_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    out_hit,
  output logic [DATA_WIDTH-1:0]   out_read_data,
  output logic [IDX_W-1:0]        out_block_index
);
  import falc_pkg::*;

  // sizes (block and word counts and memory depth are powers of two)
  localparam int MA = $clog2(MEM_WORDS);
  localparam int AB = (MA < ADDR_W) ? MA : ADDR_W;
  localparam int WB = $clog2(WORDS_PER_BLOCK);
  localparam int WBW = (WB > 0) ? WB : 1;
  localparam int TAG_W = AB - WB;
  localparam int LINES = NUM_BLOCKS * WORDS_PER_BLOCK;
  localparam int CA = $clog2(LINES);
  localparam int DV = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;
  localparam logic [DATA_WIDTH-1:0] WMASK = {DATA_WIDTH{1'b1}} >> (DATA_WIDTH - DV);

  // request registers
  logic                  req_write;
  logic [AB-1:0]         req_addr;
  logic [DATA_WIDTH-1:0] req_wdata;
  logic [TAG_W-1:0]      req_tag;
  logic [WBW-1:0]        req_word;

  // block state
  logic                  blk_valid [NUM_BLOCKS];
  logic [TAG_W-1:0]      blk_tag [NUM_BLOCKS];
  logic [AGE_W-1:0]      blk_age [NUM_BLOCKS];

  // storage
  logic [DATA_WIDTH-1:0] line_mem [LINES];
  logic [DATA_WIDTH-1:0] back_mem [MEM_WORDS];

  // sequencing registers
  logic [MA-1:0]         clr_addr;
  logic [WBW-1:0]        fill_cnt;
  logic [WBW-1:0]        fill_k;
  logic                  fill_v;
  logic [DATA_WIDTH-1:0] mem_q;
  logic [DATA_WIDTH-1:0] line_q;
  logic [DATA_WIDTH-1:0] miss_word;
  logic [IDX_W-1:0]      blk_idx;
  logic                  hit_r;

  // lookup logic
  logic                  hit;
  logic [IDX_W-1:0]      hit_idx;
  logic [IDX_W-1:0]      vic_idx;
  logic [AGE_W-1:0]      vic_age;
  logic [IDX_W-1:0]      sel_idx;
  logic [MA-1:0]         line_addr;
  logic [DATA_WIDTH-1:0] miss_data;
  logic [DATA_WIDTH-1:0] res_data;

  function automatic logic [CA-1:0] line_index(input logic [IDX_W-1:0] idx,
                                               input logic [WBW-1:0] word);
    return CA'(int'(idx) * WORDS_PER_BLOCK + int'(word));
  endfunction

  assign req_tag  = TAG_W'(req_addr / WORDS_PER_BLOCK);
  assign req_word = WBW'(req_addr % WORDS_PER_BLOCK);

  // parallel tag compare, lowest matching block wins
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int k = NUM_BLOCKS - 1; k >= 0; k--) begin
      if (blk_valid[k] && blk_tag[k] == req_tag) begin
        hit     = 1'b1;
        hit_idx = IDX_W'(k);
      end
    end
  end

  // victim is the oldest block, lowest index on ties
  always_comb begin
    vic_idx = '0;
    vic_age = blk_age[0];
    for (int k = 1; k < NUM_BLOCKS; k++) begin
      if (blk_age[k] > vic_age) begin
        vic_idx = IDX_W'(k);
        vic_age = blk_age[k];
      end
    end
  end

  assign sel_idx   = hit ? hit_idx : vic_idx;
  assign line_addr = MA'(MA'(req_tag) * WORDS_PER_BLOCK + int'(fill_cnt));

  // addressed word of a miss may still be in flight in the first finish cycle
  assign miss_data = (fill_v && fill_k == req_word) ? mem_q : miss_word;
  assign res_data  = req_write ? req_wdata : (hit_r ? line_q : miss_data);

  // status to the controller
  assign st.clear_last = (clr_addr == MA'(MEM_WORDS - 1));
  assign st.hit        = hit;
  assign st.fill_last  = (fill_cnt == WBW'(WORDS_PER_BLOCK - 1));
  assign st.out_free   = !out_valid || out_ready;

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_write <= (in_req_type == REQ_WRITE);
      req_addr  <= AB'(in_address);
      req_wdata <= in_write_data & WMASK;
    end
  end

  // valid bits and ages
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_BLOCKS; k++) begin
        blk_valid[k] <= 1'b0;
        blk_age[k]   <= AGE_RESET;
      end
    end else if (cmd.lookup) begin
      for (int k = 0; k < NUM_BLOCKS; k++) begin
        if (IDX_W'(k) == sel_idx) begin
          blk_valid[k] <= 1'b1;
          blk_age[k]   <= '0;
        end else if (blk_age[k] < AGE_MAX) begin
          blk_age[k]   <= blk_age[k] + 1'b1;
        end
      end
    end
  end

  // tags and access bookkeeping
  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      blk_tag[sel_idx] <= req_tag;
      blk_idx          <= sel_idx;
      hit_r            <= hit;
    end
  end

  // fill counter and read pipeline flag
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_v   <= 1'b0;
      fill_cnt <= '0;
    end else begin
      fill_v <= cmd.fill_rd;
      if (cmd.lookup) begin
        fill_cnt <= '0;
      end else if (cmd.fill_rd) begin
        fill_cnt <= fill_cnt + 1'b1;
      end
    end
  end

  // reset sweep address
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  // line storage: write hit, or fill with the write merged into its word
  always_ff @(posedge clk) begin
    if (cmd.lookup && hit && req_write) begin
      line_mem[line_index(hit_idx, req_word)] <= req_wdata;
    end else if (fill_v) begin
      line_mem[line_index(blk_idx, fill_k)] <=
        (req_write && fill_k == req_word) ? req_wdata : mem_q;
    end
    if (cmd.lookup && hit && !req_write) begin
      line_q <= line_mem[line_index(hit_idx, req_word)];
    end
  end

  // backing memory: reset sweep or write-through, one line word read a cycle
  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      back_mem[clr_addr] <= DATA_WIDTH'(clr_addr);
    end else if (cmd.finish && req_write) begin
      back_mem[MA'(req_addr)] <= req_wdata;
    end
    if (cmd.fill_rd) begin
      mem_q  <= back_mem[line_addr];
      fill_k <= fill_cnt;
    end
  end

  // capture of the addressed word during a fill
  always_ff @(posedge clk) begin
    if (fill_v && fill_k == req_word) begin
      miss_word <= mem_q;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_hit         <= hit_r;
      out_read_data   <= res_data;
      out_block_index <= blk_idx;
    end
  end

endmodule
